### hdl/sdx_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdx_pkg
// Shared types, character constants and byte classification functions for
// the phonetic coder.
// ----------------------------------------------------------------------------
package sdx_pkg;

   // Character constants.
   localparam logic [7:0] CHAR_LOWER_H = 8'h68;
   localparam logic [7:0] CHAR_LOWER_W = 8'h77;
   localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
   localparam logic [7:0] CHAR_DIGIT_1 = 8'h31;
   localparam logic [7:0] CHAR_DIGIT_2 = 8'h32;
   localparam logic [7:0] CHAR_DIGIT_3 = 8'h33;
   localparam logic [7:0] CHAR_DIGIT_4 = 8'h34;
   localparam logic [7:0] CHAR_DIGIT_5 = 8'h35;
   localparam logic [7:0] CHAR_DIGIT_6 = 8'h36;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
   localparam logic [7:0] CHAR_UPPER_Y = 8'h59;
   localparam logic [7:0] CASE_OFFSET  = 8'h20;

   // Number of character fields in a result item.
   localparam int OUT_FIELDS = 4;

   // Depth of the queue between front and back (a power of two).
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // One input item.
   typedef struct packed {
      logic [7:0] in_char;
      logic       in_last;
   } req_type;

   // One result item.
   typedef struct packed {
      logic [7:0] code_first;
      logic [7:0] code_second;
      logic [7:0] code_third;
      logic [7:0] code_fourth;
   } rsp_type;

   // A classified byte as it travels from front to back.
   typedef struct packed {
      logic       first;
      logic       last;
      logic       drop;
      logic       vowel;
      logic [7:0] symbol;
   } class_type;

   // Upper-case an ASCII letter; every other byte is returned unchanged.
   function automatic logic [7:0] upper_ascii(input logic [7:0] c);
      if ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z)) begin
         return c - CASE_OFFSET;
      end
      return c;
   endfunction

   // Map consonant groups onto digits; other bytes pass unchanged.
   function automatic logic [7:0] map_symbol(input logic [7:0] c);
      logic [7:0] u;
      u = upper_ascii(c);
      unique case (u) inside
         "B", "F", "P", "V":                     return CHAR_DIGIT_1;
         "C", "G", "J", "K", "Q", "S", "X", "Z": return CHAR_DIGIT_2;
         "D", "T":                               return CHAR_DIGIT_3;
         "L":                                    return CHAR_DIGIT_4;
         "M", "N":                               return CHAR_DIGIT_5;
         "R":                                    return CHAR_DIGIT_6;
         default:                                return c;
      endcase
   endfunction

   // Vowels including y, in either case.
   function automatic logic is_vowel(input logic [7:0] c);
      logic [7:0] u;
      u = upper_ascii(c);
      return (u == "A") || (u == "E") || (u == "I") || (u == "O") ||
             (u == "U") || (u == CHAR_UPPER_Y);
   endfunction

endpackage
`default_nettype wire

### hdl/sdx_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdx_front
// Accepts bytes, tracks word boundaries and classifies each byte before it
// is queued for the back end.
// ----------------------------------------------------------------------------
module sdx_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_push,
   input  wire sdx_pkg::req_type   req_data,
   input  wire logic               queue_full,
   output logic                    queue_push,
   output sdx_pkg::class_type      queue_item
);
   import sdx_pkg::*;

   logic word_start_ff;
   logic word_start_in;
   logic accept;

   assign accept     = req_push && !queue_full;
   assign queue_push = accept;

   // The byte after a last byte opens a new word.
   always_comb begin
      word_start_in = word_start_ff;
      if (accept) begin
         word_start_in = req_data.in_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_start_ff <= 1'b1;
      end else begin
         word_start_ff <= word_start_in;
      end
   end

   // Classification of the incoming byte.
   always_comb begin
      queue_item.first  = word_start_ff;
      queue_item.last   = req_data.in_last;
      queue_item.drop   = !word_start_ff &&
                          ((req_data.in_char == CHAR_LOWER_H) ||
                           (req_data.in_char == CHAR_LOWER_W));
      queue_item.vowel  = is_vowel(req_data.in_char);
      queue_item.symbol = word_start_ff ? upper_ascii(req_data.in_char)
                                        : map_symbol(req_data.in_char);
   end

endmodule
`default_nettype wire

### hdl/sdx_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdx_queue
// Short first-in first-out queue of classified bytes between front and back.
// ----------------------------------------------------------------------------
module sdx_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire sdx_pkg::class_type push_item,
   output logic                    full,
   input  wire logic               pop,
   output sdx_pkg::class_type      pop_item,
   output logic                    empty
);
   import sdx_pkg::*;

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   class_type         entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign full     = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_item = entry_ff[rd_ptr_ff];

   // Pointers wrap naturally since the depth is a power of two.
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage is written only; it needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

### hdl/sdx_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdx_back
// Removes repeats and vowels, collects the kept symbols of a word and holds
// the finished code in an output register.
// ----------------------------------------------------------------------------
module sdx_back #(
   parameter int CODE_LENGTH = 4
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire sdx_pkg::class_type queue_item,
   input  wire logic               queue_empty,
   output logic                    queue_pop,
   output logic                    rsp_empty,
   input  wire logic               rsp_pop,
   output sdx_pkg::rsp_type        rsp_data
);
   import sdx_pkg::*;

   localparam int KEEP_DEPTH = CODE_LENGTH - 1;
   localparam int CNT_W      = $clog2(KEEP_DEPTH + 1);

   logic [7:0]       lead_ff, lead_in;
   logic [7:0]       prior_ff, prior_in;
   logic             prior_valid_ff, prior_valid_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [7:0]       kept_ff [KEEP_DEPTH];
   logic [7:0]       kept_in [KEEP_DEPTH];
   logic             keep;
   logic             out_valid_ff, out_valid_in;
   rsp_type          out_data_ff, out_data_in;
   logic [7:0]       field [OUT_FIELDS];

   // Take the next item whenever the output register is free or draining.
   assign queue_pop = !queue_empty && (!out_valid_ff || rsp_pop);
   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_data_ff;

   // A symbol is kept if it is no repeat or vowel and a slot is free.
   assign keep = queue_pop && !queue_item.first && !queue_item.drop &&
                 (!prior_valid_ff || (queue_item.symbol != prior_ff)) &&
                 !queue_item.vowel && (count_ff < CNT_W'(KEEP_DEPTH));

   // Word state update.
   always_comb begin
      lead_in        = lead_ff;
      prior_in       = prior_ff;
      prior_valid_in = prior_valid_ff;
      count_in       = count_ff;
      if (queue_pop) begin
         if (queue_item.first) begin
            lead_in        = queue_item.symbol;
            prior_in       = '0;
            prior_valid_in = 1'b0;
            count_in       = '0;
         end else if (!queue_item.drop) begin
            prior_in       = queue_item.symbol;
            prior_valid_in = 1'b1;
            if (keep) begin
               count_in = count_ff + 1'b1;
            end
         end
      end
   end

   // The kept symbol lands in the slot that the fill count points at.
   always_comb begin
      for (int k = 0; k < KEEP_DEPTH; k++) begin
         kept_in[k] = (keep && (count_ff == CNT_W'(k))) ? queue_item.symbol
                                                         : kept_ff[k];
      end
   end

   // Code fields from the updated state; padding beyond the kept symbols.
   assign field[0] = lead_in;
   for (genvar j = 1; j < OUT_FIELDS; j++) begin : g_field
      if (j < CODE_LENGTH) begin : g_used
         assign field[j] = (CNT_W'(j - 1) < count_in) ? kept_in[j-1] : CHAR_DIGIT_0;
      end else begin : g_unused
         assign field[j] = 8'h00;
      end
   end

   // Output register: loaded by a last byte, cleared when taken.
   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (rsp_pop && out_valid_ff) begin
         out_valid_in = 1'b0;
      end
      if (queue_pop && queue_item.last) begin
         out_valid_in            = 1'b1;
         out_data_in.code_first  = field[0];
         out_data_in.code_second = field[1];
         out_data_in.code_third  = field[2];
         out_data_in.code_fourth = field[3];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prior_valid_ff <= 1'b0;
         count_ff       <= '0;
         out_valid_ff   <= 1'b0;
      end else begin
         prior_valid_ff <= prior_valid_in;
         count_ff       <= count_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      lead_ff     <= lead_in;
      prior_ff    <= prior_in;
      out_data_ff <= out_data_in;
      for (int k = 0; k < KEEP_DEPTH; k++) begin
         kept_ff[k] <= kept_in[k];
      end
   end

endmodule
`default_nettype wire

### hdl/soundex_phonetic_code.sv
`default_nettype none
// ----------------------------------------------------------------------------
// soundex_phonetic_code
// Phonetic coder: takes a word one byte per item and gives a four-character
// code when the last byte of the word arrives.
//
//   Channel   Ports                          Moves
//   input     req_push, req_full, req_data   one byte and its last flag
//   result    rsp_empty, rsp_pop, rsp_data   one code per word
//
// One item is taken every cycle while req_full is low. The front classifies a
// byte in the cycle it is offered and registers only the word-start flag, so the
// byte goes straight into the two-entry queue; the back end consumes it at the
// earliest in the cycle after it enters the queue. A last byte passes through the
// queue and the output register before its code appears on the result ports.
// Reset is synchronous and empties the queue and the output register.
// A stalled result fills the queue, after which req_full stays high until
// the result is popped.
// ----------------------------------------------------------------------------
module soundex_phonetic_code #(
   parameter int CODE_LENGTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_push,
   output logic                  req_full,
   input  wire sdx_pkg::req_type req_data,
   output logic                  rsp_empty,
   input  wire logic             rsp_pop,
   output sdx_pkg::rsp_type      rsp_data
);
   import sdx_pkg::*;

   logic      front_push;
   class_type front_item;
   class_type queue_item;
   logic      queue_empty;
   logic      queue_pop;

   // Front: word tracking and classification.
   sdx_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_data   (req_data),
      .queue_full (req_full),
      .queue_push (front_push),
      .queue_item (front_item)
   );

   // Queue between front and back.
   sdx_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_push),
      .push_item (front_item),
      .full      (req_full),
      .pop       (queue_pop),
      .pop_item  (queue_item),
      .empty     (queue_empty)
   );

   // Back: repeat and vowel removal, code assembly.
   sdx_back #(
      .CODE_LENGTH (CODE_LENGTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_item  (queue_item),
      .queue_empty (queue_empty),
      .queue_pop   (queue_pop),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_data    (rsp_data)
   );

   // The back end never reads an empty queue.
   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      queue_pop |-> !queue_empty)
      else $error("queue popped while empty");

   // The back end never idles while work waits and the output is free.
   a_back_not_idle: assert property (@(posedge clock) disable iff (reset)
      (!queue_empty && rsp_empty) |-> queue_pop)
      else $error("back end idle with work pending");

   // A consumed last byte always produces a visible result.
   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      (queue_pop && queue_item.last) |=> !rsp_empty)
      else $error("last byte produced no result");

endmodule
`default_nettype wire
